/* rtl/cosine_cutoff_function_macros.svh */
// Assertion helpers for the cosine cutoff block.
`ifndef COSINE_CUTOFF_FUNCTION_MACROS_SVH
`define COSINE_CUTOFF_FUNCTION_MACROS_SVH

// Check a property every clock edge outside of reset.
`define CCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cosine cutoff check failed");

// Check a property every clock edge, reset included.
`define CCF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cosine cutoff check failed");

`endif

/* rtl/ccf_pkg.sv */
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared constants, types and elaboration-time helpers of the cutoff block.
// ----------------------------------------------------------------------------
package ccf_pkg;

  localparam int TRIG_FRAC_BITS = 24;

  localparam int DIST_W  = 24;
  localparam int SCALE_W = 32;
  localparam int VALUE_W = 17;
  localparam int GRAD_W  = 32;
  localparam int PHASE_W = DIST_W + SCALE_W;   // Q12.44 product
  localparam int MOD_STEPS = 10;               // quotient of phase/2pi < 2^10

  localparam logic [23:0] RADIUS_RESET = 24'd393216;
  localparam logic [31:0] SCALE_RESET  = 32'd140552482;

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q44      = (PI_Q60 + (64'd1 << 15)) >> 16;
  localparam logic [63:0] TWO_PI_Q44  = PI_Q44 << 1;
  localparam logic [63:0] HALF_PI_Q44 = PI_Q44 >> 1;
  localparam logic [63:0] THREE_HALF_PI_Q44 = PI_Q44 + HALF_PI_Q44;
  localparam logic [63:0] GAIN_Q32    = 64'd2608131496;

  // Register indexes of the configuration port.
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_SCALE  = 1'b1;

  // Control word that travels with each pipeline slot.
  typedef struct packed {
    logic valid;
    logic zero;   // distance at or beyond the cutoff radius
    logic flip;   // negate cos and sin at the end
  } ctl_t;

  // atan(2^-i) in Q62, evaluated at elaboration only.
  function automatic logic [63:0] atan_q62(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int k;
    acc = 64'd0;
    if (i == 0) return PI_Q60;
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

endpackage

/* rtl/cosine_cutoff_function.sv */
// ----------------------------------------------------------------------------
// cosine_cutoff_function
// Cosine cutoff value 0.5*(cos(r*s)+1) and gradient -0.5*s*sin(r*s).
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one distance word per handshake (unsigned Q8.16).
//   Output stream m_*: one result word per distance, in order, holding the
//   cutoff value (unsigned Q1.16) and the gradient (signed Q7.24).
//   Distances at or beyond cutoff_radius give a zero value and gradient.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 cutoff_radius, 1 phase_scale); write only while the pipe is empty.
// Throughput: one word per cycle; the pipeline takes a new word every
//   cycle the output side is not stalled.
// Pipeline: a phase product register, the modulo-2*pi subtract chain,
//   a fold register, a register per CORDIC micro-rotation, then the
//   scaling register and the output register.
// Reset: clears all valid bits and loads the register defaults (radius
//   6.0, scale pi/6). No clearing pass is needed.
// Stall: when m_tready is low with a word waiting, the whole pipe holds
//   and s_tready drops in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "cosine_cutoff_function_macros.svh"

module cosine_cutoff_function #(
  parameter int TRIG_FRAC_BITS = ccf_pkg::TRIG_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [23:0] distance
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // [16:0] cutoff_value, [48:17] cutoff_gradient
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int ZW = TRIG_FRAC_BITS + 3;

  logic [23:0] cutoff_radius;
  logic [31:0] phase_scale;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_radius <= ccf_pkg::RADIUS_RESET;
      phase_scale   <= ccf_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccf_pkg::REG_RADIUS: cutoff_radius <= cfg_data[23:0];
        ccf_pkg::REG_SCALE:  phase_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless a finished word is waiting and m_tready is low.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  ccf_pkg::ctl_t             ctl_ph, ctl_co;
  logic signed [ZW-1:0]      z_ph, cos_co, sin_co;
  logic [16:0]               value;
  logic [31:0]               gradient;

  ccf_phase #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_phase (
    .clk, .rst, .en,
    .in_valid      (s_tvalid),
    .distance      (s_tdata),
    .cutoff_radius (cutoff_radius),
    .phase_scale   (phase_scale),
    .ctl_out       (ctl_ph),
    .z_out         (z_ph)
  );

  ccf_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic (
    .clk, .rst, .en,
    .ctl_in  (ctl_ph),
    .z_in    (z_ph),
    .ctl_out (ctl_co),
    .cos_out (cos_co),
    .sin_out (sin_co)
  );

  ccf_post #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_post (
    .clk, .rst, .en,
    .ctl_in          (ctl_co),
    .cos_in          (cos_co),
    .sin_in          (sin_co),
    .phase_scale     (phase_scale),
    .out_valid       (m_tvalid),
    .cutoff_value    (value),
    .cutoff_gradient (gradient)
  );

  assign m_tdata = {7'd0, gradient, value};

  // Checks.
  `CCF_ASSERT(a_value_range, m_tvalid |-> (m_tdata[16:0] <= 17'd65536))
  `CCF_ASSERT(a_ready_tracks_stall, s_tready == (!m_tvalid || m_tready))
  `CCF_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> !m_tvalid)

endmodule

/* rtl/ccf_phase.sv */
// ----------------------------------------------------------------------------
// ccf_phase
// Phase product, reduction modulo 2*pi and fold into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module ccf_phase #(
  parameter int TRIG_FRAC_BITS = ccf_pkg::TRIG_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [23:0]              distance,
  input  logic [23:0]              cutoff_radius,
  input  logic [31:0]              phase_scale,
  output ccf_pkg::ctl_t            ctl_out,
  output logic signed [TRIG_FRAC_BITS+2:0] z_out
);
  localparam int PW = ccf_pkg::PHASE_W;
  localparam int NS = ccf_pkg::MOD_STEPS;
  localparam int ZW = TRIG_FRAC_BITS + 3;
  localparam int AW = 47;
  localparam int SH = 44 - TRIG_FRAC_BITS;

  logic [PW-1:0]   a   [0:NS];
  ccf_pkg::ctl_t   ctl [0:NS];

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0].valid <= in_valid;
      ctl[0].zero  <= distance >= cutoff_radius;
      ctl[0].flip  <= 1'b0;
    end
    if (en) a[0] <= PW'(distance) * PW'(phase_scale);
  end

  // One conditional subtract of 2*pi*2^k per stage, high k first.
  for (genvar j = 0; j < NS; j++) begin : g_mod
    localparam logic [PW-1:0] C = PW'(ccf_pkg::TWO_PI_Q44 << (NS - 1 - j));
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[j+1] <= '0;
      end else if (en) begin
        ctl[j+1] <= ctl[j];
      end
      if (en) a[j+1] <= (a[j] >= C) ? a[j] - C : a[j];
    end
  end

  // Fold and round to the CORDIC angle format.
  logic [AW-1:0] ar, mag;
  logic          neg, flip;
  logic [AW-1:0] rnd;
  logic [ZW-1:0] zmag;

  always_comb begin
    ar   = a[NS][AW-1:0];
    neg  = 1'b0;
    flip = 1'b0;
    if (ar > AW'(ccf_pkg::THREE_HALF_PI_Q44)) begin
      mag = AW'(ccf_pkg::TWO_PI_Q44) - ar;
      neg = 1'b1;
    end else if (ar > AW'(ccf_pkg::HALF_PI_Q44)) begin
      flip = 1'b1;
      if (ar >= AW'(ccf_pkg::PI_Q44)) begin
        mag = ar - AW'(ccf_pkg::PI_Q44);
      end else begin
        mag = AW'(ccf_pkg::PI_Q44) - ar;
        neg = 1'b1;
      end
    end else begin
      mag = ar;
    end
    rnd  = (mag + (AW'(1) << (SH - 1))) >> SH;
    zmag = rnd[ZW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid <= ctl[NS].valid;
      ctl_out.zero  <= ctl[NS].zero;
      ctl_out.flip  <= flip;
    end
    if (en) z_out <= neg ? -$signed(zmag) : $signed(zmag);
  end

endmodule

/* rtl/ccf_cordic.sv */
// ----------------------------------------------------------------------------
// ccf_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ccf_cordic #(
  parameter int TRIG_FRAC_BITS = ccf_pkg::TRIG_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  ccf_pkg::ctl_t                     ctl_in,
  input  logic signed [TRIG_FRAC_BITS+2:0]  z_in,
  output ccf_pkg::ctl_t                     ctl_out,
  output logic signed [TRIG_FRAC_BITS+2:0]  cos_out,
  output logic signed [TRIG_FRAC_BITS+2:0]  sin_out
);
  localparam int F = TRIG_FRAC_BITS;
  localparam int W = F + 3;
  localparam logic [W-1:0] X0 =
    W'((ccf_pkg::GAIN_Q32 + (64'd1 << (31 - F))) >> (32 - F));

  logic signed [W-1:0] x [0:F];
  logic signed [W-1:0] y [0:F];
  logic signed [W-1:0] z [0:F];
  ccf_pkg::ctl_t       ctl [0:F];

  assign x[0]   = $signed(X0);
  assign y[0]   = '0;
  assign z[0]   = z_in;
  assign ctl[0] = ctl_in;

  for (genvar i = 0; i < F; i++) begin : g_rot
    localparam logic [W-1:0] STEP =
      W'((ccf_pkg::atan_q62(i) + (64'd1 << (61 - F))) >> (62 - F));
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1] <= '0;
      end else if (en) begin
        ctl[i+1] <= ctl[i];
      end
      if (en) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed(STEP);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed(STEP);
        end
      end
    end
  end

  assign ctl_out = ctl[F];
  assign cos_out = ctl[F].flip ? -x[F] : x[F];
  assign sin_out = ctl[F].flip ? -y[F] : y[F];

endmodule

/* rtl/ccf_post.sv */
// ----------------------------------------------------------------------------
// ccf_post
// Value and gradient scaling, rounding and saturation; output register.
// ----------------------------------------------------------------------------
module ccf_post #(
  parameter int TRIG_FRAC_BITS = ccf_pkg::TRIG_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  ccf_pkg::ctl_t                     ctl_in,
  input  logic signed [TRIG_FRAC_BITS+2:0]  cos_in,
  input  logic signed [TRIG_FRAC_BITS+2:0]  sin_in,
  input  logic [31:0]                       phase_scale,
  output logic                              out_valid,
  output logic [16:0]                       cutoff_value,
  output logic [31:0]                       cutoff_gradient
);
  localparam int F  = TRIG_FRAC_BITS;
  localparam int W  = F + 3;
  localparam int SW = W + 1;          // room for cos + 1
  localparam int PRW = 32 + W;
  localparam int VS = F + 1 - 16;     // value shift, may be negative
  localparam int GS = F + 5;

  logic signed [SW-1:0] sum;
  logic [SW+16:0]       vwide;
  logic [16:0]          val;
  logic                 sneg;
  logic [W-1:0]         smag;

  always_comb begin
    sum = SW'(cos_in) + (SW'(1) << F);
    if (sum < 0) sum = '0;
    if (sum > (SW'(1) << (F + 1))) sum = SW'(1) << (F + 1);
    if (VS > 0) vwide = ((SW+17)'(sum) + ((SW+17)'(1) << (VS > 0 ? VS - 1 : 0))) >>
                        (VS > 0 ? VS : 0);
    else vwide = (SW+17)'(sum) << (VS > 0 ? 0 : -VS);
    val  = (vwide > (SW+17)'(65536)) ? 17'd65536 : vwide[16:0];
    sneg = sin_in < 0;
    smag = sneg ? W'(-sin_in) : W'(sin_in);
  end

  // Stage A: product and value.
  ccf_pkg::ctl_t    ctl_a;
  logic [PRW-1:0]   prod_a;
  logic             sneg_a;
  logic [16:0]      val_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a <= ctl_in;
    end
    if (en) begin
      prod_a <= PRW'(phase_scale) * PRW'(smag);
      sneg_a <= sneg;
      val_a  <= val;
    end
  end

  // Stage B: round, saturate, sign, output register.
  logic [PRW-1:0] gmag;
  logic [31:0]    g;

  always_comb begin
    gmag = (prod_a + (PRW'(1) << (GS - 1))) >> GS;
    if (sneg_a) begin
      g = (gmag > PRW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : gmag[31:0];
    end else begin
      g = (gmag > PRW'(33'h080000000)) ? 32'h80000000 : 32'(-gmag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_a.valid;
    end
    if (en) begin
      cutoff_value    <= ctl_a.zero ? 17'd0 : val_a;
      cutoff_gradient <= ctl_a.zero ? 32'd0 : g;
    end
  end

endmodule

/* verif/cosine_cutoff_function_tb.sv */
// ----------------------------------------------------------------------------
// cosine_cutoff_function_tb
// Streams distances through the cosine cutoff block under random idling and
// backpressure and checks every result word against a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cosine_cutoff_function_tb;

  localparam int FB = ccf_pkg::TRIG_FRAC_BITS;
  localparam int LATENCY = FB + 14;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [ccf_pkg::GRAD_W-1:0]  gradient;
    logic [ccf_pkg::VALUE_W-1:0] value;
  } cutoff_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = ccf_pkg::REG_RADIUS;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the two registers.
  logic [23:0] radius_q = ccf_pkg::RADIUS_RESET;
  logic [31:0] scale_q  = ccf_pkg::SCALE_RESET;

  cutoff_result_t expected_results[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_len = 0;
  int  hold_cycles = 0;
  bit  hold_seen = 1'b0;
  int  quiet_cycles = 0;

  cosine_cutoff_function dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] round_shr(input logic [63:0] v, input int k);
    if (k <= 0) return v << (-k);
    return (v + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
                                                    input int k);
    return v >>> k;  // arithmetic shift already rounds toward minus infinity
  endfunction

  function automatic logic [63:0] arctan_q62(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int k;
    acc = 64'd0;
    if (i == 0) return ccf_pkg::PI_Q60;
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic cutoff_result_t cutoff_of(input logic [23:0] dist_word);
    cutoff_result_t r;
    logic [63:0] phase, a, mag, val, smag, gmag;
    logic signed [63:0] x, y, z, dx, dy, stp, sum;
    logic [127:0] prod;
    bit neg, flip;
    r = '0;
    if (dist_word >= radius_q) return r;
    phase = 64'(dist_word) * 64'(scale_q);
    a = phase % ccf_pkg::TWO_PI_Q44;
    neg = 0; flip = 0;
    // fold the phase into [-pi/2, pi/2]
    if (a > ccf_pkg::THREE_HALF_PI_Q44) begin
      mag = ccf_pkg::TWO_PI_Q44 - a; neg = 1;
    end else if (a > ccf_pkg::HALF_PI_Q44) begin
      flip = 1;
      if (a >= ccf_pkg::PI_Q44) mag = a - ccf_pkg::PI_Q44;
      else begin
        mag = ccf_pkg::PI_Q44 - a; neg = 1;
      end
    end else begin
      mag = a;
    end
    z = round_shr(mag, 44 - FB);
    if (neg) z = -z;
    x = round_shr(ccf_pkg::GAIN_Q32, 32 - FB);
    y = 0;
    for (int i = 0; i < FB; i++) begin
      stp = round_shr(arctan_q62(i), 62 - FB);
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= stp;
      end else begin
        x += dx; y -= dy; z += stp;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sum = x + (64'sd1 <<< FB);
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< (FB + 1))) sum = 64'sd1 <<< (FB + 1);
    val = round_shr(sum, FB + 1 - 16);
    if (val > 65536) val = 65536;
    smag = (y < 0) ? -y : y;
    prod = 128'(scale_q) * 128'(smag) + (128'd1 << (FB + 4));
    gmag = 64'(prod >> (FB + 5));
    if (y < 0) begin
      if (gmag > 64'd2147483647) gmag = 64'd2147483647;
      r.gradient = gmag[31:0];
    end else begin
      if (gmag > 64'd2147483648) gmag = 64'd2147483648;
      r.gradient = 32'(-gmag);
    end
    r.value = val[16:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Present one distance word and hold it until the block accepts it.
  task automatic send_distance(input logic [23:0] dist_word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= dist_word;
    expected_results.push_back(cutoff_of(dist_word));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ccf_pkg::REG_RADIUS) radius_q = data[23:0];
    else scale_q = data;
  endtask

  // Mostly distances inside the cutoff, some beyond and some full-range noise.
  function automatic logic [23:0] rand_distance();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7 && radius_q != 0) return 24'($urandom_range(radius_q - 1));
    if (pick < 9) return 24'($urandom_range(24'hFFFFFF, radius_q));
    return 24'($urandom);
  endfunction

  // Receiver: random stalls plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      hold_cycles <= 0;
      hold_seen   <= 1'b0;
    end else begin
      if (hold_len != 0 && !hold_seen) begin
        hold_cycles <= hold_len;
        hold_seen   <= 1'b1;
        m_tready    <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready    <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (hold_len == 0) hold_seen <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cutoff_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[48:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          errors++;
        end
        if (got.gradient !== want.gradient) begin
          $display("%0t: gradient expected %h actual %h", $time, want.gradient,
                   got.gradient);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cosine_cutoff_function_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    logic [23:0] pts[$];
    pts = {24'd0, 24'd1, 24'd65536, 24'd131072, 24'd196608, 24'd262144,
           24'd393215, 24'd393216, 24'd393217, 24'hFFFFFF, 24'h800000,
           24'h555555, 24'hAAAAAA};
    foreach (pts[i]) send_distance(pts[i]);
    drain();
    // zero radius: everything lands beyond the cutoff
    write_reg(ccf_pkg::REG_RADIUS, 32'd0);
    send_distance(24'd0);
    send_distance(24'hFFFFFF);
    drain();
    // full radius, maximum scale: phase wraps past 2*pi
    write_reg(ccf_pkg::REG_RADIUS, 32'hFFFFFF);
    write_reg(ccf_pkg::REG_SCALE, 32'hFFFFFFFF);
    foreach (pts[i]) if (i < 8) send_distance(pts[i]);
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_distance(rand_distance());
    drain();
  endtask

  task automatic test_settings_sweep();
    logic [31:0] scales[4];
    logic [23:0] radii[4];
    scales = '{32'd0, 32'd1, ccf_pkg::SCALE_RESET, 32'($urandom)};
    radii  = '{24'd1, 24'hFFFFFF, ccf_pkg::RADIUS_RESET, 24'($urandom)};
    for (int i = 0; i < 4; i++) begin
      write_reg(ccf_pkg::REG_RADIUS, {8'd0, radii[i]});
      write_reg(ccf_pkg::REG_SCALE, scales[i]);
      test_random_phase(20, 20, 100);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = 200;
    repeat (120) send_distance(rand_distance());
    hold_len = 0;
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_reg(ccf_pkg::REG_RADIUS, {8'd0, ccf_pkg::RADIUS_RESET});
    write_reg(ccf_pkg::REG_SCALE, ccf_pkg::SCALE_RESET);
    test_random_phase(0, 0, 300);
    test_random_phase(48, 0, 250);
    test_random_phase(0, 48, 250);
    test_random_phase(33, 33, 250);
    test_settings_sweep();
    write_reg(ccf_pkg::REG_RADIUS, 32'd4194304);
    write_reg(ccf_pkg::REG_SCALE, 32'd51471854);
    test_backpressure();
    if (errors == 0) $display("cosine_cutoff_function_tb: PASS");
    else $display("cosine_cutoff_function_tb: FAIL");
    $finish;
  end

endmodule
